// ----- sv/att_pkg.sv -----
`timescale 1ns / 1ps

package att_pkg;

  // Default table depth
  localparam int unsigned TableEntriesDef = 64;

  // Field widths
  localparam int unsigned AddrW  = 32;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned ByteW  = 48;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned InDataW  = AddrW + SizeW;
  localparam int unsigned OutDataW = 4 * CountW + 4 * ByteW;

  // Event codes
  typedef enum logic [FuncW-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // Result codes
  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_UNTRACKED = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // One table row
  typedef struct packed {
    logic             vld;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] size;
  } row_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic clr_ctrs;
    logic scan;
    logic sweep;
    logic apply;
    logic peak;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_clear;
    logic is_active;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [CountW-1:0] sat_inc32(input logic [CountW-1:0] a);
    return (a == '1) ? a : a + CountW'(1);
  endfunction

  function automatic logic [CountW-1:0] floor_dec32(input logic [CountW-1:0] a);
    return (a == '0) ? a : a - CountW'(1);
  endfunction

  function automatic logic [ByteW-1:0] sat_add48(input logic [ByteW-1:0] a,
                                                 input logic [SizeW-1:0] b);
    logic [ByteW:0] s;
    s = {1'b0, a} + (ByteW + 1)'(b);
    return s[ByteW] ? '1 : s[ByteW-1:0];
  endfunction

  function automatic logic [ByteW-1:0] floor_sub48(input logic [ByteW-1:0] a,
                                                   input logic [SizeW-1:0] b);
    return (a > ByteW'(b)) ? a - ByteW'(b) : '0;
  endfunction

endpackage

// ----- sv/att_ctrl.sv -----
`timescale 1ns / 1ps

module att_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  att_pkg::dp_stat_t   stat_i,
  output att_pkg::ctrl_cmd_t  cmd_o
);
  import att_pkg::*;

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_CLEAR  = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_TAIL   = 9'b000100000,
    S_APPLY  = 9'b001000000,
    S_PEAK   = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.scan_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.load = s_axis_tvalid;
        if (s_axis_tvalid) state_d = S_DECODE;
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (stat_i.is_clear) begin
          cmd_o.clr_ctrs = 1'b1;
          state_d = S_CLEAR;
        end else if (stat_i.is_active) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.scan_last) state_d = S_EMIT;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) state_d = S_TAIL;
      end
      S_TAIL: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d = S_PEAK;
      end
      S_PEAK: begin
        cmd_o.peak = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

endmodule

// ----- sv/att_datapath.sv -----
`timescale 1ns / 1ps

module att_datapath #(
  parameter int unsigned TABLE_ENTRIES = att_pkg::TableEntriesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  att_pkg::ctrl_cmd_t             cmd_i,
  output att_pkg::dp_stat_t              stat_o,
  input  logic [att_pkg::InDataW-1:0]    s_tdata_i,
  input  logic [att_pkg::FuncW-1:0]      s_tuser_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i,
  input  logic                           m_tready_i,
  output logic                           m_tvalid_o,
  output logic [att_pkg::OutDataW-1:0]   m_tdata_o,
  output logic [att_pkg::StatW-1:0]      m_tuser_o
);
  import att_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  // Table storage
  row_t table_mem [TABLE_ENTRIES];
  row_t rd_row_q;

  // Latched event
  func_e             func_q;
  logic [AddrW-1:0]  addr_q;
  logic [SizeW-1:0]  size_q;
  logic              en_q;

  // Search state
  logic [IdxW-1:0]   scan_idx_q, rd_idx_q, hit_idx_q, free_idx_q;
  logic              rd_pend_q, hit_q, free_q;
  logic [SizeW-1:0]  hit_size_q;

  // Statistics
  logic [CountW-1:0] live_q, live_d, live_peak_q, live_peak_d;
  logic [CountW-1:0] alloc_tot_q, alloc_tot_d, free_tot_q, free_tot_d;
  logic [ByteW-1:0]  level_q, level_d, byte_peak_q, byte_peak_d;
  logic [ByteW-1:0]  balloc_q, balloc_d, bfreed_q, bfreed_d;
  status_e           status_q, status_d;

  // Output register
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  status_e             m_user_q;

  logic          alloc_ok, free_ok, wr_en, out_load;
  logic [IdxW-1:0] wr_idx;
  row_t          wr_row;

  // Event decode
  assign alloc_ok = (func_q == FUNC_ALLOC) && (hit_q || free_q);
  assign free_ok  = (func_q == FUNC_FREE) && hit_q;

  assign stat_o.is_clear  = (func_q == FUNC_CLEAR);
  assign stat_o.is_active = ((func_q == FUNC_ALLOC) || (func_q == FUNC_FREE)) &&
                            en_q && (addr_q != '0);
  assign stat_o.scan_last = (scan_idx_q == LastIdx);
  assign stat_o.out_free  = !m_valid_q || m_tready_i;

  assign out_load    = cmd_i.emit && stat_o.out_free;
  assign cfg_ready_o = 1'b1;

  // Table write port: clearing sweep or update of the chosen row
  always_comb begin
    wr_en  = cmd_i.sweep || (cmd_i.apply && (alloc_ok || free_ok));
    wr_idx = cmd_i.sweep ? scan_idx_q : (hit_q ? hit_idx_q : free_idx_q);
    wr_row = '0;
    if (!cmd_i.sweep && alloc_ok) begin
      wr_row.vld  = 1'b1;
      wr_row.addr = addr_q;
      wr_row.size = size_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) table_mem[wr_idx] <= wr_row;
    rd_row_q <= table_mem[scan_idx_q];
  end

  // Event capture and search results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(s_tuser_i);
      addr_q <= s_tdata_i[AddrW-1:0];
      size_q <= s_tdata_i[InDataW-1:AddrW];
    end
    rd_idx_q <= scan_idx_q;
    if (rd_pend_q && rd_row_q.vld && (rd_row_q.addr == addr_q) && !hit_q) begin
      hit_idx_q  <= rd_idx_q;
      hit_size_q <= rd_row_q.size;
    end
    if (rd_pend_q && !rd_row_q.vld && !free_q) free_idx_q <= rd_idx_q;
    status_q <= status_d;
  end

  // Search control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      rd_pend_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      en_q       <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan;
      if (cfg_valid_i) en_q <= cfg_data_i;
      if (cmd_i.decode) begin
        scan_idx_q <= '0;
        hit_q      <= 1'b0;
        free_q     <= 1'b0;
      end else begin
        if (cmd_i.scan || cmd_i.sweep) scan_idx_q <= scan_idx_q + IdxW'(1);
        if (rd_pend_q && rd_row_q.vld && (rd_row_q.addr == addr_q)) hit_q <= 1'b1;
        if (rd_pend_q && !rd_row_q.vld) free_q <= 1'b1;
      end
    end
  end

  // Counter updates
  always_comb begin
    live_d      = live_q;
    live_peak_d = live_peak_q;
    alloc_tot_d = alloc_tot_q;
    free_tot_d  = free_tot_q;
    level_d     = level_q;
    byte_peak_d = byte_peak_q;
    balloc_d    = balloc_q;
    bfreed_d    = bfreed_q;
    status_d    = status_q;
    if (cmd_i.decode) begin
      if (stat_o.is_clear) status_d = ST_OK;
      else if (!stat_o.is_active) status_d = ST_IGNORED;
    end
    if (cmd_i.clr_ctrs) begin
      live_d      = '0;
      live_peak_d = '0;
      alloc_tot_d = '0;
      free_tot_d  = '0;
      level_d     = '0;
      byte_peak_d = '0;
      balloc_d    = '0;
      bfreed_d    = '0;
    end else if (cmd_i.apply) begin
      if (func_q == FUNC_ALLOC) status_d = alloc_ok ? ST_OK : ST_FULL;
      else status_d = free_ok ? ST_OK : ST_UNTRACKED;
      if (alloc_ok) begin
        alloc_tot_d = sat_inc32(alloc_tot_q);
        live_d      = sat_inc32(live_q);
        balloc_d    = sat_add48(balloc_q, size_q);
        level_d     = sat_add48(level_q, size_q);
      end else if (free_ok) begin
        free_tot_d = sat_inc32(free_tot_q);
        live_d     = floor_dec32(live_q);
        bfreed_d   = sat_add48(bfreed_q, hit_size_q);
        level_d    = floor_sub48(level_q, hit_size_q);
      end
    end else if (cmd_i.peak) begin
      if (live_q > live_peak_q) live_peak_d = live_q;
      if (level_q > byte_peak_q) byte_peak_d = level_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      live_peak_q <= '0;
      alloc_tot_q <= '0;
      free_tot_q  <= '0;
      level_q     <= '0;
      byte_peak_q <= '0;
      balloc_q    <= '0;
      bfreed_q    <= '0;
    end else begin
      live_q      <= live_d;
      live_peak_q <= live_peak_d;
      alloc_tot_q <= alloc_tot_d;
      free_tot_q  <= free_tot_d;
      level_q     <= level_d;
      byte_peak_q <= byte_peak_d;
      balloc_q    <= balloc_d;
      bfreed_q    <= bfreed_d;
    end
  end

  // Result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {bfreed_q, balloc_q, free_tot_q, alloc_tot_q,
                   byte_peak_q, level_q, live_peak_q, live_q};
      m_user_q <= status_q;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

endmodule

// ----- sv/allocation_tracking_table.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser func, tdata address, size
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser status, tdata counters
// cfg       in         cfg_valid_i/cfg_ready_o       cfg_data_i tracking enable
//
// One event at a time. Allocate/free: a linear search of the table through its one read
// port, then the tail, apply, peak and emit states. Clear: a row-by-row invalidation
// sweep, then emit. Ignored: straight to emit. After reset a clearing pass runs before
// the first beat is taken. A stalled result sits in the output register; the next
// event is taken meanwhile and waits for it before its own result is loaded.

module allocation_tracking_table #(
  parameter int unsigned TABLE_ENTRIES = att_pkg::TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [att_pkg::InDataW-1:0]   s_axis_tdata,  // address[31:0], alloc_size[63:32]
  input  logic [att_pkg::FuncW-1:0]     s_axis_tuser,  // func[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // current_allocations[31:0], peak_allocations[63:32], current_bytes[111:64],
  // peak_bytes[159:112], total_allocations[191:160], total_deallocations[223:192],
  // total_bytes_allocated[271:224], total_bytes_freed[319:272]
  output logic [att_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [att_pkg::StatW-1:0]     m_axis_tuser,  // status[1:0]
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i
);
  import att_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  att_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  att_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

  // One event in flight: ready drops right after an accepted beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an event is in flight");

  // Live count never exceeds its peak in a result
  a_live_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:0] <= m_axis_tdata[63:32]))
    else $error("current allocations above peak");

  // Byte level never exceeds its peak in a result
  a_bytes_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[111:64] <= m_axis_tdata[159:112]))
    else $error("current bytes above peak");

  // A result loaded into a free output register shows up next cycle
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && stat.out_free |=> m_axis_tvalid)
    else $error("result not presented after load");

endmodule

// ----- tb/tb_allocation_tracking_table.sv -----
`timescale 1ns / 1ps

module tb_allocation_tracking_table;
  import att_pkg::*;

  localparam int LONG_HOLD  = 400;   // receiver hold-off, cycles
  localparam int SETTLE_CYC = 80;    // > worst event latency

  // Counter fields as they sit in m_axis_tdata, lowest field last
  typedef struct packed {
    logic [ByteW-1:0]  freed_bytes;  // total_bytes_freed
    logic [ByteW-1:0]  alloc_bytes;  // total_bytes_allocated
    logic [CountW-1:0] frees;        // total_deallocations
    logic [CountW-1:0] allocs;       // total_allocations
    logic [ByteW-1:0]  peak_bytes;
    logic [ByteW-1:0]  cur_bytes;
    logic [CountW-1:0] peak_allocs;
    logic [CountW-1:0] cur_allocs;
  } usage_t;

  typedef struct packed {
    status_e st;
    usage_t  u;
  } report_t;

  // Mirror of the table and counters; queues the report each event should give
  class usage_ledger;
    bit                tracking;
    bit                used [TableEntriesDef];
    logic [AddrW-1:0]  tag  [TableEntriesDef];
    logic [SizeW-1:0]  bytes[TableEntriesDef];
    usage_t            cnt;
    report_t           due_reports[$];
    int                status_seen[4];
    int                checked;
    int                mismatches;

    function new();
      tracking = 1'b0;
      wipe();
    endfunction

    function void wipe();
      foreach (used[i]) begin
        used[i]  = 1'b0;
        tag[i]   = '0;
        bytes[i] = '0;
      end
      cnt = '0;
    endfunction

    function logic [CountW-1:0] bump32(logic [CountW-1:0] a);
      return (a == {CountW{1'b1}}) ? a : a + 1'b1;
    endfunction

    function logic [ByteW-1:0] add_sat48(logic [ByteW-1:0] a, logic [SizeW-1:0] b);
      logic [ByteW-1:0] top;
      top = {ByteW{1'b1}};
      return (a > top - ByteW'(b)) ? top : a + ByteW'(b);
    endfunction

    function int slot_of(logic [AddrW-1:0] addr);
      foreach (used[i])
        if (used[i] && tag[i] == addr) return i;
      return -1;
    endfunction

    function int first_empty();
      foreach (used[i])
        if (!used[i]) return i;
      return -1;
    endfunction

    function int live_rows();
      int n;
      n = 0;
      foreach (used[i]) n += used[i];
      return n;
    endfunction

    // Random tracked address, zero when the table is empty
    function logic [AddrW-1:0] any_live();
      int idx[$];
      foreach (used[i])
        if (used[i]) idx = {idx, i};
      if (idx.size() == 0) return '0;
      return tag[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    // Apply one accepted event and queue the report it must produce
    function void book_event(func_e f, logic [AddrW-1:0] addr, logic [SizeW-1:0] size);
      report_t r;
      int      slot;
      r.st = ST_IGNORED;
      if (f == FUNC_CLEAR) begin
        wipe();
        r.st = ST_OK;
      end else if (f != FUNC_NOP && tracking && addr != '0) begin
        slot = slot_of(addr);
        if (f == FUNC_ALLOC) begin
          if (slot < 0) slot = first_empty();
          if (slot < 0) begin
            r.st = ST_FULL;
          end else begin
            used[slot]      = 1'b1;
            tag[slot]       = addr;
            bytes[slot]     = size;
            cnt.allocs      = bump32(cnt.allocs);
            cnt.cur_allocs  = bump32(cnt.cur_allocs);
            cnt.alloc_bytes = add_sat48(cnt.alloc_bytes, size);
            cnt.cur_bytes   = add_sat48(cnt.cur_bytes, size);
            if (cnt.cur_allocs > cnt.peak_allocs) cnt.peak_allocs = cnt.cur_allocs;
            if (cnt.cur_bytes > cnt.peak_bytes) cnt.peak_bytes = cnt.cur_bytes;
            r.st = ST_OK;
          end
        end else if (slot < 0) begin
          r.st = ST_UNTRACKED;
        end else begin
          cnt.frees       = bump32(cnt.frees);
          cnt.cur_allocs  = (cnt.cur_allocs == '0) ? '0 : cnt.cur_allocs - 1'b1;
          cnt.freed_bytes = add_sat48(cnt.freed_bytes, bytes[slot]);
          cnt.cur_bytes   = (cnt.cur_bytes > ByteW'(bytes[slot])) ?
                            cnt.cur_bytes - ByteW'(bytes[slot]) : '0;
          used[slot]      = 1'b0;
          r.st = ST_OK;
        end
      end
      r.u = cnt;
      due_reports = {due_reports, r};
      status_seen[r.st]++;
    endfunction

    function void note_diff(string name, logic [ByteW-1:0] exp, logic [ByteW-1:0] act);
      if (act !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH report %0d %s: expected 0x%0h, got 0x%0h",
                   checked, name, exp, act);
      end
    endfunction

    // Compare one output beat against the oldest queued report
    function void match_report(logic [StatW-1:0] st, usage_t got);
      report_t e;
      checked++;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH report %0d arrived with none outstanding", checked);
        return;
      end
      e = due_reports.pop_front();
      note_diff("status",                ByteW'(e.st),          ByteW'(st));
      note_diff("current_allocations",   e.u.cur_allocs,  got.cur_allocs);
      note_diff("peak_allocations",      e.u.peak_allocs, got.peak_allocs);
      note_diff("current_bytes",         e.u.cur_bytes,   got.cur_bytes);
      note_diff("peak_bytes",            e.u.peak_bytes,  got.peak_bytes);
      note_diff("total_allocations",     e.u.allocs,      got.allocs);
      note_diff("total_deallocations",   e.u.frees,       got.frees);
      note_diff("total_bytes_allocated", e.u.alloc_bytes, got.alloc_bytes);
      note_diff("total_bytes_freed",     e.u.freed_bytes, got.freed_bytes);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // address[31:0], alloc_size[63:32]
  logic [FuncW-1:0]    s_axis_tuser = '0;   // func[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // counters, current_allocations lowest
  logic [StatW-1:0]    m_axis_tuser;        // status[1:0]
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_data_i = 1'b0;

  usage_ledger ledger = new();
  bit          calm = 1'b0;      // no idling on either side
  bit          hold_req = 1'b0;  // asks the receiver for one long hold-off
  int          gap_pct = 0;      // sender idle chance per beat
  int          item_cnt = 0;
  int          toggles = 0;

  allocation_tracking_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Offer one event and wait for the beat to be taken
  task automatic offer(input func_e f, input logic [AddrW-1:0] addr,
                       input logic [SizeW-1:0] size);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {size, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.book_event(f, addr, size);
    item_cnt++;
  endtask

  task automatic pause(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic push_event(input func_e f, input logic [AddrW-1:0] addr,
                            input logic [SizeW-1:0] size);
    if (!calm && $urandom_range(0, 99) < gap_pct) pause($urandom_range(1, 14));
    offer(f, addr, size);
  endtask

  // Sender stops until every outstanding report has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (ledger.due_reports.size() != 0);
  endtask

  task automatic set_tracking(input bit on);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= on;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.tracking = on;
    cfg_valid_i <= 1'b0;
    toggles++;
  endtask

  function automatic logic [SizeW-1:0] rand_size();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return $urandom_range(1, 65536);
    endcase
  endfunction

  function automatic logic [AddrW-1:0] fresh_addr();
    logic [AddrW-1:0] a;
    do a = $urandom; while (a == '0 || ledger.slot_of(a) >= 0);
    return a;
  endfunction

  // Mostly live alloc/free traffic, with reallocs, stray frees, nulls and noise
  task automatic mixed_traffic(input int n);
    int               r;
    func_e            f;
    logic [AddrW-1:0] a;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        f = FUNC_ALLOC; a = fresh_addr();
      end else if (r < 52) begin
        f = FUNC_ALLOC; a = ledger.any_live();
        if (a == '0) a = fresh_addr();
      end else if (r < 78) begin
        f = FUNC_FREE; a = ledger.any_live();
        if (a == '0) a = fresh_addr();
      end else if (r < 84) begin
        f = FUNC_FREE; a = fresh_addr();
      end else if (r < 89) begin
        f = ($urandom_range(0, 1) != 0) ? FUNC_FREE : FUNC_ALLOC; a = '0;
      end else if (r < 93) begin
        f = FUNC_NOP; a = $urandom;
      end else if (r < 95) begin
        f = FUNC_CLEAR; a = $urandom;
      end else begin
        f = func_e'($urandom_range(0, 3)); a = $urandom;
      end
      push_event(f, a, rand_size());
    end
  endtask

  // Allocate until the table is full, then hit the full case from several sides
  task automatic fill_table();
    int extra;
    extra = $urandom_range(1, 3);
    while (ledger.live_rows() < TableEntriesDef)
      push_event(FUNC_ALLOC, fresh_addr(), rand_size());
    repeat (extra) push_event(FUNC_ALLOC, fresh_addr(), rand_size());
    push_event(FUNC_ALLOC, ledger.any_live(), rand_size());  // realloc still fits
    push_event(FUNC_FREE, ledger.any_live(), rand_size());
    push_event(FUNC_ALLOC, fresh_addr(), rand_size());
    push_event(FUNC_ALLOC, fresh_addr(), rand_size());
  endtask

  task automatic empty_table();
    while (ledger.live_rows() > 0)
      push_event(FUNC_FREE, ledger.any_live(), rand_size());
  endtask

  task automatic random_traffic(input int until_cnt);
    int pick;
    while (item_cnt < until_cnt) begin
      pick    = $urandom_range(0, 99);
      gap_pct = 5 * $urandom_range(0, 6);
      if (pick < 60)      mixed_traffic($urandom_range(10, 30));
      else if (pick < 72) fill_table();
      else if (pick < 87) empty_table();
      else                drain();
    end
  endtask

  // Output side: check each beat, stall in random bursts, honor the long hold
  initial begin : report_sink
    int stall_left;
    int hold_left;
    int window;
    int stall_pct;
    stall_left = 0;
    hold_left  = 0;
    window     = 0;
    stall_pct  = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) ledger.match_report(m_axis_tuser, m_axis_tdata);
      if (window == 0) begin
        window    = 150;
        stall_pct = 10 * $urandom_range(0, 3);
      end else begin
        window--;
      end
      if (hold_req) begin
        hold_req  <= 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 14) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // tracking off after reset: only clear has effect
    push_event(FUNC_ALLOC, 32'h0000_1000, 32'd16);
    push_event(FUNC_FREE,  32'h0000_1000, 32'd0);
    push_event(FUNC_CLEAR, 32'h0000_0000, 32'h0);
    push_event(FUNC_NOP,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_tracking(1'b1);

    // field extremes, null, realloc, stray free, clear with junk fields
    push_event(FUNC_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_event(FUNC_ALLOC, 32'h0000_0001, 32'h0);
    push_event(FUNC_ALLOC, 32'h0000_0000, 32'd5);
    push_event(FUNC_FREE,  32'h0000_0000, 32'd0);
    push_event(FUNC_ALLOC, 32'hFFFF_FFFF, 32'h8000_0000);
    push_event(FUNC_FREE,  32'h1234_5678, 32'hFFFF_FFFF);
    push_event(FUNC_FREE,  32'h0000_0001, 32'h0);
    push_event(FUNC_NOP,   32'hA5A5_5A5A, 32'h5A5A_A5A5);
    push_event(FUNC_ALLOC, 32'h8000_0000, 32'h7FFF_FFFF);
    push_event(FUNC_FREE,  32'hFFFF_FFFF, 32'h0);
    push_event(FUNC_CLEAR, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
    push_event(FUNC_ALLOC, 32'h5555_AAAA, 32'hAAAA_5555);
    push_event(FUNC_FREE,  32'h5555_AAAA, 32'h0);

    gap_pct = 10;
    fill_table();

    // receiver holds off while the sender keeps offering
    hold_req <= 1'b1;
    mixed_traffic(12);

    random_traffic(200);

    // tracking off mid-run, then back on
    set_tracking(1'b0);
    mixed_traffic(15);
    set_tracking(1'b1);

    random_traffic(380);

    // no idling for the tail
    drain();
    calm = 1'b1;
    mixed_traffic(50);

    drain();
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Run covered %0d events: %0d recorded, %0d untracked frees, %0d ignored, %0d full",
             item_cnt, ledger.status_seen[ST_OK], ledger.status_seen[ST_UNTRACKED],
             ledger.status_seen[ST_IGNORED], ledger.status_seen[ST_FULL]);
    $display("%0d reports checked, %0d mismatches, %0d enable writes",
             ledger.checked, ledger.mismatches, toggles);
    if (ledger.mismatches == 0 && ledger.due_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d reports outstanding", ledger.due_reports.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
